/* hw/rtl/lbcp_pkg.sv */
// ----------------------------------------------------------------------------
// lbcp_pkg: shared types and constants of the line block cut and paste engine
// Field widths, command and status codes, the job record passed from the
// front end to the back end, and the back end state encoding.
// ----------------------------------------------------------------------------
package lbcp_pkg;

    // Width of a position or line-count field.
    localparam int POS_W = 11;
    // Width of a stored line number.
    localparam int VAL_W = 11;

    localparam int MAX_LINES_DEFAULT = 1024;
    localparam int LINE_COUNT_RESET  = 1024;

    // Job queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Stream data widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    // One classified item. Positions are zero-based where noted.
    typedef struct packed {
        logic             cmd;
        logic             bad;  // range check failed, nothing to do
        logic [POS_W-1:0] st0;  // first position of block or read, zero-based
        logic [POS_W-1:0] k;    // block length
        logic [POS_W-1:0] ins;  // lines of the remainder ahead of the block
        logic [POS_W-1:0] n;    // lines in use
    } t_job;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ_WAIT,
        ST_COPY,
        ST_PASTE
    } t_back_state;

endpackage

/* hw/rtl/lbcp_front.sv */
// ----------------------------------------------------------------------------
// lbcp_front: item intake and range classification
// Holds the line count register, checks each incoming item against it and
// pushes a classified job into the queue.
// ----------------------------------------------------------------------------
module lbcp_front #(
    parameter int MAX_LINES = lbcp_pkg::MAX_LINES_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lbcp_pkg::POS_W-1:0] i_cfg_wdata,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_command,
    input  logic [lbcp_pkg::POS_W-1:0] i_cut_start,
    input  logic [lbcp_pkg::POS_W-1:0] i_cut_end,
    input  logic [lbcp_pkg::POS_W-1:0] i_insert_after,
    input  logic                      i_init_busy,
    input  logic                      i_queue_full,
    output logic                      o_push,
    output lbcp_pkg::t_job            o_job
);

    localparam int PW      = lbcp_pkg::POS_W;
    localparam int POS_MAX = (1 << PW) - 1;
    // Largest usable count: capacity, or what the field can express.
    localparam logic [PW-1:0] CAP = PW'((MAX_LINES > POS_MAX) ? POS_MAX : MAX_LINES);

    logic [PW-1:0] r_line_count;
    logic [PW-1:0] used;
    logic [PW-1:0] blk_len;
    logic [PW-1:0] rest;
    logic          move_bad;
    logic          read_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= PW'(lbcp_pkg::LINE_COUNT_RESET);
        end else if (i_cfg_we) begin
            r_line_count <= i_cfg_wdata;
        end
    end

    always_comb begin
        used    = (r_line_count > CAP) ? CAP : r_line_count;
        blk_len = i_cut_end - i_cut_start + PW'(1);
        rest    = used - blk_len;
        // The remainder test only matters once the block itself is in range.
        move_bad = (i_cut_start == '0) || (i_cut_start > i_cut_end) ||
                   (i_cut_end > used) || (i_insert_after > rest);
        read_bad = (i_cut_start == '0) || (i_cut_start > used);

        o_job.cmd = i_command;
        o_job.bad = (i_command == lbcp_pkg::CMD_READ) ? read_bad : move_bad;
        o_job.st0 = i_cut_start - PW'(1);
        o_job.k   = blk_len;
        o_job.ins = i_insert_after;
        o_job.n   = used;
    end

    assign o_ready = !i_queue_full && !i_init_busy;
    assign o_push  = i_valid && o_ready;

endmodule

/* hw/rtl/lbcp_queue.sv */
// ----------------------------------------------------------------------------
// lbcp_queue: short job queue
// A small first-in first-out buffer of classified jobs between the front end
// and the back end.
// ----------------------------------------------------------------------------
module lbcp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lbcp_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output lbcp_pkg::t_job o_data,
    output logic           o_empty
);

    localparam int DEPTH = lbcp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lbcp_pkg::t_job r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hw/rtl/lbcp_back.sv */
// ----------------------------------------------------------------------------
// lbcp_back: job execution over the line store
// Owns the line store and the copy buffer, runs the fill pass after
// reset, serves reads and carries out moves as a copy pass and a paste pass.
// ----------------------------------------------------------------------------
module lbcp_back #(
    parameter int MAX_LINES = lbcp_pkg::MAX_LINES_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  lbcp_pkg::t_job             i_job,
    output logic                       o_pop,
    output logic                       o_init_busy,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [lbcp_pkg::VAL_W-1:0] o_line_value,
    output logic                       o_status
);

    localparam int AW = $clog2(MAX_LINES);
    localparam int PW = lbcp_pkg::POS_W;
    localparam int VW = lbcp_pkg::VAL_W;

    logic [VW-1:0] line_store [MAX_LINES];
    logic [VW-1:0] cut_buffer [MAX_LINES];

    lbcp_pkg::t_back_state r_state, n_state;
    lbcp_pkg::t_job        r_job, n_job;
    logic [AW-1:0] r_init_idx, n_init_idx;
    logic [PW-1:0] r_cnt, n_cnt;
    logic          r_v1, n_v1;
    logic [PW-1:0] r_a1, n_a1;
    logic          r_out_valid, n_out_valid;
    logic [VW-1:0] r_out_value, n_out_value;
    logic          r_out_status, n_out_status;

    logic          store_we;
    logic [AW-1:0] store_waddr;
    logic [VW-1:0] store_wdata;
    logic [AW-1:0] store_raddr;
    logic [VW-1:0] r_store_rdata;
    logic          cut_we;
    logic [AW-1:0] cut_waddr;
    logic [AW-1:0] cut_raddr;
    logic [VW-1:0] r_cut_rdata;

    logic [PW-1:0] blk_end;
    logic [PW-1:0] rem_idx;
    logic [PW-1:0] src;
    logic          out_free;

    // Source position in the copy for new position r_cnt.
    always_comb begin
        blk_end = r_job.ins + r_job.k;
        rem_idx = (r_cnt < r_job.ins) ? r_cnt : r_cnt - r_job.k;
        if ((r_cnt >= r_job.ins) && (r_cnt < blk_end)) begin
            src = r_job.st0 + (r_cnt - r_job.ins);
        end else begin
            src = (rem_idx < r_job.st0) ? rem_idx : rem_idx + r_job.k;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_job        = r_job;
        n_init_idx   = r_init_idx;
        n_cnt        = r_cnt;
        n_v1         = 1'b0;
        n_a1         = r_cnt;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        store_we     = 1'b0;
        store_waddr  = AW'(r_a1);
        store_wdata  = r_cut_rdata;
        store_raddr  = AW'(r_cnt);
        cut_we       = 1'b0;
        cut_waddr    = AW'(r_a1);
        cut_raddr    = AW'(src);
        o_pop        = 1'b0;

        unique case (r_state)
            lbcp_pkg::ST_INIT: begin
                store_we    = 1'b1;
                store_waddr = r_init_idx;
                store_wdata = VW'(r_init_idx) + VW'(1);
                n_init_idx  = r_init_idx + AW'(1);
                if (r_init_idx == AW'(MAX_LINES - 1)) begin
                    n_state = lbcp_pkg::ST_IDLE;
                end
            end
            lbcp_pkg::ST_IDLE: begin
                store_raddr = AW'(i_job.st0);
                if (i_job_valid && out_free) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    n_cnt = '0;
                    if (i_job.bad) begin
                        n_out_valid  = 1'b1;
                        n_out_value  = '0;
                        n_out_status = lbcp_pkg::STATUS_BAD;
                    end else if (i_job.cmd == lbcp_pkg::CMD_READ) begin
                        n_state = lbcp_pkg::ST_READ_WAIT;
                    end else begin
                        n_state = lbcp_pkg::ST_COPY;
                    end
                end
            end
            lbcp_pkg::ST_READ_WAIT: begin
                n_out_valid  = 1'b1;
                n_out_value  = r_store_rdata;
                n_out_status = lbcp_pkg::STATUS_DONE;
                n_state      = lbcp_pkg::ST_IDLE;
            end
            lbcp_pkg::ST_COPY: begin
                if (r_cnt != r_job.n) begin
                    n_v1  = 1'b1;
                    n_cnt = r_cnt + PW'(1);
                end
                cut_we = r_v1;
                if ((r_cnt == r_job.n) && !r_v1) begin
                    n_cnt   = '0;
                    n_state = lbcp_pkg::ST_PASTE;
                end
            end
            lbcp_pkg::ST_PASTE: begin
                if (r_cnt != r_job.n) begin
                    n_v1  = 1'b1;
                    n_cnt = r_cnt + PW'(1);
                end
                store_we = r_v1;
                if ((r_cnt == r_job.n) && !r_v1) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_status = lbcp_pkg::STATUS_DONE;
                    n_state      = lbcp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lbcp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbcp_pkg::ST_INIT;
            r_init_idx  <= '0;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_idx  <= n_init_idx;
            r_v1        <= n_v1;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job        <= n_job;
        r_cnt        <= n_cnt;
        r_a1         <= n_a1;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            line_store[store_waddr] <= store_wdata;
        end
        r_store_rdata <= line_store[store_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cut_we) begin
            cut_buffer[cut_waddr] <= r_store_rdata;
        end
        r_cut_rdata <= cut_buffer[cut_raddr];
    end

    assign o_init_busy  = (r_state == lbcp_pkg::ST_INIT);
    assign o_out_valid  = r_out_valid;
    assign o_line_value = r_out_value;
    assign o_status     = r_out_status;

endmodule

/* hw/rtl/line_block_cut_paste_top.sv */
// ----------------------------------------------------------------------------
// line_block_cut_paste_top: line sequence with block cut and paste
// Keeps an ordered sequence of line numbers, moves blocks within it and
// answers reads of single positions.
// ----------------------------------------------------------------------------
// After reset the block fills the line store so that position p holds line
// p; the input stays not ready during that pass, while writes of the line
// count register are taken at any time. Each item then gives exactly one
// result. A read of a valid position goes through the job queue, the read
// wait state and the output register; an item that fails its range check
// goes through the job queue and the output register. For a move the back
// end streams the whole in-use part of the store into a copy buffer, one
// entry per cycle through the single store read port, and then writes every
// in-use position back from that copy in its new order. The front end
// classifies items and keeps a two-entry job queue filled while a move is
// running; a finished result waits in the output register, and the back
// end takes no new job from the queue until that register is free.
// Positions at or beyond the line count are never touched.
module line_block_cut_paste_top #(
    parameter int MAX_LINES = lbcp_pkg::MAX_LINES_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Line count register write.
    input  logic                            i_cfg_we,
    input  logic [lbcp_pkg::POS_W-1:0]      i_cfg_wdata,
    // Input items.
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: cut_start [10:0], cut_end [21:11], insert_after [32:22], zero pad.
    input  logic [lbcp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: command.
    input  logic                            i_s_axis_tuser,
    // Result items.
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: line_value [10:0], zero pad.
    output logic [lbcp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: status.
    output logic                            o_m_axis_tuser
);

    localparam int PW = lbcp_pkg::POS_W;
    localparam int VW = lbcp_pkg::VAL_W;

    logic           w_init_busy;
    logic           w_queue_full;
    logic           w_queue_empty;
    logic           w_push;
    logic           w_pop;
    lbcp_pkg::t_job w_front_job;
    lbcp_pkg::t_job w_head_job;
    logic [VW-1:0]  w_line_value;

    // Intake and range checks against the current line count.
    lbcp_front #(
        .MAX_LINES(MAX_LINES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_command      (i_s_axis_tuser),
        .i_cut_start    (i_s_axis_tdata[PW-1:0]),
        .i_cut_end      (i_s_axis_tdata[2*PW-1:PW]),
        .i_insert_after (i_s_axis_tdata[3*PW-1:2*PW]),
        .i_init_busy    (w_init_busy),
        .i_queue_full   (w_queue_full),
        .o_push         (w_push),
        .o_job          (w_front_job)
    );

    // Jobs wait here so that intake and execution stall independently.
    lbcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_job),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_data  (w_head_job),
        .o_empty (w_queue_empty)
    );

    // Execution over the line store, with the result register at its output.
    lbcp_back #(
        .MAX_LINES(MAX_LINES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (!w_queue_empty),
        .i_job        (w_head_job),
        .o_pop        (w_pop),
        .o_init_busy  (w_init_busy),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_line_value (w_line_value),
        .o_status     (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {{(lbcp_pkg::OUT_TDATA_W - VW){1'b0}}, w_line_value};

    // A rejected item never reports a line.
    a_bad_has_no_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == lbcp_pkg::STATUS_BAD))
            |-> (o_m_axis_tdata == '0))
        else $error("rejected item carries a nonzero line value");

    // No item is taken while the store is still being filled.
    a_no_intake_during_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init_busy |-> !o_s_axis_tready)
        else $error("item accepted during the store fill");

    // The front end never pushes into a full queue.
    a_no_queue_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_queue_full)
        else $error("job pushed into a full queue");

    // No result appears while the store is still being filled.
    a_no_result_during_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init_busy |-> !o_m_axis_tvalid)
        else $error("result presented during the store fill");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the line block cut and paste engine
// Drives move and read items on the input stream and predicts every result
// from a local copy of the line sequence. Each result is checked field by
// field against the oldest prediction. The run covers several line counts,
// sender idling, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int POS_W       = lbcp_pkg::POS_W;
    localparam int VAL_W       = lbcp_pkg::VAL_W;
    localparam int IN_TDATA_W  = lbcp_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = lbcp_pkg::OUT_TDATA_W;
    localparam int LINE_CAP    = lbcp_pkg::MAX_LINES_DEFAULT;
    localparam int CYCLE_LIMIT = 4_000_000;
    // A move over the whole store runs a copy pass and a paste pass over it.
    localparam int SETTLE_CYCLES = 2 * LINE_CAP + 64;
    localparam int HOLD_CYCLES   = 500;
    localparam int IN_PAD_W      = IN_TDATA_W - 3 * POS_W;
    localparam int OUT_PAD_W     = OUT_TDATA_W - VAL_W;

    // One input item as the bench sees it. wait_idle makes the sender hold
    // the item back until every earlier result has come out.
    typedef struct packed {
        logic             cmd;
        logic [POS_W-1:0] st;
        logic [POS_W-1:0] en;
        logic [POS_W-1:0] ins;
        logic             wait_idle;
    } t_line_op;

    typedef struct packed {
        logic [31:0]      op_index;
        logic [VAL_W-1:0] line_value;
        logic             status;
    } t_line_result;

    // Clock, reset and all block inputs start from known values.
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [POS_W-1:0]       i_cfg_wdata     = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                   i_s_axis_tuser  = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;

    // Predicted contents of the line store and the line count register.
    logic [VAL_W-1:0] line_seq [LINE_CAP];
    logic [POS_W-1:0] cfg_line_count = POS_W'(lbcp_pkg::LINE_COUNT_RESET);

    t_line_op     pending_ops [$];
    t_line_result expected_results [$];
    t_line_op     offered_op;
    t_line_result predicted;
    t_line_result oldest;

    int ops_accepted   = 0;
    int results_taken  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold_left   = 0;
    logic rx_hold_start = 1'b0;

    line_block_cut_paste_top #(
        .MAX_LINES(LINE_CAP)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        // tdata: cut_start [10:0], cut_end [21:11], insert_after [32:22], pad.
        .i_s_axis_tdata  (i_s_axis_tdata),
        // tuser: command.
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        // tdata: line_value [10:0], pad.
        .o_m_axis_tdata  (o_m_axis_tdata),
        // tuser: status.
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one item to the predicted sequence and returns its result.
    // A move rebuilds the in-use part as: the first ins lines of the
    // remainder, then the cut block, then the rest of the remainder. Lines
    // at or beyond the count are left alone.
    function automatic t_line_result apply_line_op(t_line_op op);
        t_line_result     r;
        int               n;
        int               st;
        int               en;
        int               ins;
        int               k;
        int               j;
        int               w;
        logic [VAL_W-1:0] rest [LINE_CAP];
        logic [VAL_W-1:0] blk  [LINE_CAP];
        r.op_index   = '0;
        r.line_value = '0;
        r.status     = lbcp_pkg::STATUS_DONE;
        n   = (int'(cfg_line_count) > LINE_CAP) ? LINE_CAP : int'(cfg_line_count);
        st  = int'(op.st);
        en  = int'(op.en);
        ins = int'(op.ins);
        if (op.cmd == lbcp_pkg::CMD_READ) begin
            if (st >= 1 && st <= n)
                r.line_value = line_seq[st-1];
            else
                r.status = lbcp_pkg::STATUS_BAD;
        end else if (st < 1 || st > en || en > n || ins > n - (en - st + 1)) begin
            r.status = lbcp_pkg::STATUS_BAD;
        end else begin
            k = en - st + 1;
            w = 0;
            for (j = 0; j < n; j++) begin
                if (j < st - 1 || j >= en) begin
                    rest[w] = line_seq[j];
                    w = w + 1;
                end else begin
                    blk[j-st+1] = line_seq[j];
                end
            end
            for (j = 0; j < ins; j++)
                line_seq[j] = rest[j];
            for (j = 0; j < k; j++)
                line_seq[ins+j] = blk[j];
            for (j = ins; j < n - k; j++)
                line_seq[k+j] = rest[j];
        end
        return r;
    endfunction

    // Mostly well-formed moves and reads with random content, the rest
    // near-miss moves and reads just outside the legal range and raw noise.
    function automatic t_line_op random_line_op(int n);
        t_line_op op;
        int       sel;
        int       st;
        int       en;
        int       ins;
        int       d;
        sel = $urandom_range(99);
        op.wait_idle = ($urandom_range(99) < 3);
        op.cmd = lbcp_pkg::CMD_MOVE;
        st  = 0;
        en  = 0;
        ins = 0;
        if (n == 0 || sel >= 85) begin
            op.cmd = 1'($urandom_range(1));
            st  = $urandom_range(2047);
            en  = $urandom_range(2047);
            ins = $urandom_range(2047);
        end else if (sel >= 70) begin
            st  = $urandom_range(n, 1);
            en  = $urandom_range(n, st);
            ins = n - (en - st + 1);
            case ($urandom_range(4))
                0: ins = ins + 1;
                1: en = n + 1;
                2: st = en + 1;
                3: st = 0;
                default: begin
                    op.cmd = lbcp_pkg::CMD_READ;
                    st = ($urandom_range(1) != 0) ? n + 1 : 0;
                end
            endcase
        end else if (sel >= 35) begin
            op.cmd = lbcp_pkg::CMD_READ;
            st  = $urandom_range(n, 1);
            en  = $urandom_range(2047);
            ins = $urandom_range(2047);
        end else begin
            st = $urandom_range(n, 1);
            if ($urandom_range(1) != 0) begin
                d  = int'($urandom_range(3));
                en = (st + d > n) ? n : st + d;
            end else begin
                en = $urandom_range(n, st);
            end
            ins = $urandom_range(n - (en - st + 1), 0);
        end
        op.st  = POS_W'(st);
        op.en  = POS_W'(en);
        op.ins = POS_W'(ins);
        return op;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40)
            $display("ERROR: %s", what);
        mismatch_count++;
    endtask

    task automatic push_op(input logic cmd, input int st, input int en, input int ins,
                           input bit wait_idle);
        t_line_op op;
        op.cmd       = cmd;
        op.st        = POS_W'(st);
        op.en        = POS_W'(en);
        op.ins       = POS_W'(ins);
        op.wait_idle = wait_idle;
        pending_ops.push_back(op);
    endtask

    // Returns once every queued item has gone in and every result has come
    // out, plus a short settle time.
    task automatic wait_drained();
        while (pending_ops.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Only called while the block is idle, so the predicted register can
    // change at once.
    task automatic write_line_count(input int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= POS_W'(value);
        cfg_line_count = POS_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random_phase(input int count, input int items, input int idle_pct,
                                    input int stall_pct, input bit hold_off);
        int n;
        int i;
        write_line_count(count);
        n = (count > LINE_CAP) ? LINE_CAP : count;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (i = 0; i < items; i++)
            pending_ops.push_back(random_line_op(n));
        if (hold_off) begin
            // The receiver stops for a long stretch while the sender keeps
            // offering, so the job queue and output register fill up.
            @(posedge i_clk);
            rx_hold_start <= 1'b1;
            @(posedge i_clk);
            rx_hold_start <= 1'b0;
            // After the hold-off, one item waits until the block is empty.
            wait (rx_hold_left != 0);
            wait (rx_hold_left == 0);
            push_op(lbcp_pkg::CMD_READ, 1, 0, 0, 1'b1);
        end
        wait_drained();
    endtask

    // Sender: offers the head of the pending queue, holds each item until it
    // is taken, and predicts its result at the edge where it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predicted = apply_line_op(offered_op);
                predicted.op_index = ops_accepted;
                expected_results.push_back(predicted);
                ops_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_ops.size() != 0
                    && !(pending_ops[0].wait_idle && ops_accepted != results_taken)
                    && $urandom_range(99) >= send_idle_pct) begin
                    offered_op = pending_ops.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser  <= offered_op.cmd;
                    i_s_axis_tdata  <= {{IN_PAD_W{1'b0}}, offered_op.ins, offered_op.en,
                                        offered_op.st};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_taken <= results_taken + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with no item waiting: data %h status %b",
                                              o_m_axis_tdata, o_m_axis_tuser));
                end else begin
                    oldest = expected_results.pop_front();
                    if (o_m_axis_tdata !== {{OUT_PAD_W{1'b0}}, oldest.line_value})
                        report_mismatch($sformatf("item %0d: line_value %h, expected %h",
                                                  oldest.op_index, o_m_axis_tdata,
                                                  oldest.line_value));
                    if (o_m_axis_tuser !== oldest.status)
                        report_mismatch($sformatf("item %0d: status %b, expected %b",
                                                  oldest.op_index, o_m_axis_tuser,
                                                  oldest.status));
                end
            end
            i_m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Counts down the receiver hold-off.
    always @(posedge i_clk) begin
        if (rx_hold_start)
            rx_hold_left <= HOLD_CYCLES;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // Guard against a hung block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("line_block_cut_paste_top: mismatch");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < LINE_CAP; i++)
            line_seq[i] = VAL_W'(i + 1);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at the reset line count. The block is still
        // filling its store, so these wait at the input until it is ready.
        push_op(lbcp_pkg::CMD_READ, 1, 0, 0, 1'b0);
        push_op(lbcp_pkg::CMD_READ, 1024, 0, 0, 1'b0);
        push_op(lbcp_pkg::CMD_READ, 0, 0, 0, 1'b0);         // read of position zero
        push_op(lbcp_pkg::CMD_READ, 1025, 0, 0, 1'b0);      // read past the count
        push_op(lbcp_pkg::CMD_READ, 2047, 2047, 2047, 1'b0);
        push_op(lbcp_pkg::CMD_MOVE, 0, 5, 0, 1'b0);         // start of zero
        push_op(lbcp_pkg::CMD_MOVE, 6, 5, 0, 1'b0);         // start after end
        push_op(lbcp_pkg::CMD_MOVE, 1, 1025, 0, 1'b0);      // end past the count
        push_op(lbcp_pkg::CMD_MOVE, 1, 10, 1015, 1'b0);     // insert point too far
        push_op(lbcp_pkg::CMD_MOVE, 2047, 2047, 2047, 1'b0);
        push_op(lbcp_pkg::CMD_MOVE, 1, 1024, 0, 1'b0);      // whole sequence as block
        push_op(lbcp_pkg::CMD_MOVE, 1, 10, 1014, 1'b0);     // block to the very end
        push_op(lbcp_pkg::CMD_READ, 1024, 0, 0, 1'b0);
        push_op(lbcp_pkg::CMD_READ, 1, 0, 0, 1'b0);
        push_op(lbcp_pkg::CMD_MOVE, 1024, 1024, 0, 1'b0);   // last line to the front
        push_op(lbcp_pkg::CMD_READ, 1, 0, 0, 1'b1);
        push_op(lbcp_pkg::CMD_MOVE, 500, 500, 500, 1'b0);
        push_op(lbcp_pkg::CMD_READ, 500, 0, 0, 1'b0);
        wait_drained();

        // With no lines in use, every item is flagged.
        write_line_count(0);
        push_op(lbcp_pkg::CMD_MOVE, 1, 1, 0, 1'b0);
        push_op(lbcp_pkg::CMD_READ, 1, 0, 0, 1'b0);
        wait_drained();

        // A count above capacity acts as a full store.
        write_line_count(2047);
        push_op(lbcp_pkg::CMD_READ, 1024, 0, 0, 1'b0);
        push_op(lbcp_pkg::CMD_READ, 1025, 0, 0, 1'b0);
        push_op(lbcp_pkg::CMD_MOVE, 1, 1024, 0, 1'b0);
        wait_drained();

        // Random phases over several counts and flow patterns.
        run_random_phase(1, 20, 0, 0, 1'b0);
        run_random_phase(8, 50, 83, 0, 1'b0);
        run_random_phase(33, 50, 0, 83, 1'b0);
        run_random_phase(200, 40, 30, 30, 1'b0);
        run_random_phase(1024, 30, 0, 0, 1'b0);
        run_random_phase(16, 45, 0, 0, 1'b1);
        run_random_phase(5, 30, 30, 30, 1'b0);

        // Give any stray result time to show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatch_count == 0)
            $display("line_block_cut_paste_top: match");
        else
            $display("line_block_cut_paste_top: mismatch");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lbcp_pkg.sv
hw/rtl/lbcp_front.sv
hw/rtl/lbcp_queue.sv
hw/rtl/lbcp_back.sv
hw/rtl/line_block_cut_paste_top.sv
test/tb_top.sv
